// ===== rtl/core/smpd_pkg.sv =====
package smpd_pkg;

    // field widths
    localparam int unsigned BYTE_W  = 7;
    localparam int unsigned DELTA_W = 8;
    localparam int unsigned LOW_W   = 6;

    // bit positions inside a sync byte
    localparam int unsigned SYNC_IDX  = 6;
    localparam int unsigned LEFT_IDX  = 5;
    localparam int unsigned RIGHT_IDX = 4;

    // packet position: bytes of the current packet received so far
    typedef enum logic [1:0] {
        CNT_WAIT   = 2'd0,
        CNT_HEADER = 2'd1,
        CNT_SECOND = 2'd2
    } count_t;

    // one received byte on its way from the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } rx_stage_t;

    // one decoded packet
    typedef struct packed {
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic                      left_press;
        logic                      left_release;
        logic                      right_press;
        logic                      right_release;
    } result_t;

endpackage

// ===== rtl/core/serial_mouse_packet_decoder_top.sv =====
// serial mouse packet decoder, three-byte serial mouse protocol
//
// input channel: in_valid / in_stall with rx_byte, one 7-bit byte per request.
// a byte with bit 6 set starts a packet; the two following bytes carry the
// low six bits of x and y. stray data bytes outside a packet are dropped.
// output channel: out_valid / out_stall with delta_x, delta_y and the four
// button flags, one request per complete packet.
// a third byte goes from the input register through the single decode step
// into the result register, which raises out_valid. throughput: one byte per
// cycle, set by those two registers, unless a stalled result holds the input.
// reset (rst_n low, asynchronous) empties both registers, returns to waiting
// for a sync byte and clears the held button flags.
// when out_stall is high with a result waiting, the result holds and the
// input register stays full; in_stall rises only once that byte is held.
module serial_mouse_packet_decoder_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [smpd_pkg::BYTE_W-1:0]      rx_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [smpd_pkg::DELTA_W-1:0] delta_x,
    output logic signed [smpd_pkg::DELTA_W-1:0] delta_y,
    output logic                             left_press,
    output logic                             left_release,
    output logic                             right_press,
    output logic                             right_release
);
    import smpd_pkg::*;

    rx_stage_t stage;
    result_t   result;
    result_t   held;
    logic      advance;
    logic      emit;

    smpd_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .stage    (stage)
    );

    smpd_decode u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .emit    (emit),
        .result  (result)
    );

    smpd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .result    (result),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .held      (held)
    );

    assign delta_x       = held.delta_x;
    assign delta_y       = held.delta_y;
    assign left_press    = held.left_press;
    assign left_release  = held.left_release;
    assign right_press   = held.right_press;
    assign right_release = held.right_release;

endmodule

// ===== rtl/core/smpd_in_stage.sv =====
module smpd_in_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [smpd_pkg::BYTE_W-1:0] rx_byte,
    input  logic                      advance,
    output smpd_pkg::rx_stage_t       stage
);
    import smpd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;

    // stall only while a held byte cannot move on
    assign in_stall = valid_reg && !advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    // control flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // byte capture on request
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            data_reg <= rx_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

// ===== rtl/core/smpd_decode.sv =====
module smpd_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  smpd_pkg::rx_stage_t stage,
    input  logic                advance,
    output logic                emit,
    output smpd_pkg::result_t   result
);
    import smpd_pkg::*;

    count_t            count_reg;
    count_t            count_next;
    logic [LOW_W-1:0]  header_reg;
    logic [BYTE_W-1:0] second_reg;
    logic              left_held_reg;
    logic              right_held_reg;
    logic              consume;
    logic              sync;
    logic              lbtn;
    logic              rbtn;

    assign consume = stage.valid && advance;
    assign sync    = stage.data[SYNC_IDX];
    assign lbtn    = header_reg[LEFT_IDX];
    assign rbtn    = header_reg[RIGHT_IDX];

    // packet position next state
    always_comb
    begin
        count_next = count_reg;
        if (consume)
        begin
            if (sync)
            begin
                count_next = CNT_HEADER;
            end
            else
            begin
                case (count_reg)
                    CNT_HEADER: count_next = CNT_SECOND;
                    default:    count_next = CNT_WAIT;
                endcase
            end
        end
    end

    // result on the third byte of a packet
    always_comb
    begin
        case (count_reg)
            CNT_SECOND: emit = stage.valid && !sync;
            default:    emit = 1'b0;
        endcase
        result.delta_x       = {header_reg[1:0], second_reg[LOW_W-1:0]};
        result.delta_y       = {header_reg[3:2], stage.data[LOW_W-1:0]};
        result.left_press    = lbtn;
        result.left_release  = !lbtn && left_held_reg;
        result.right_press   = rbtn;
        result.right_release = !rbtn && right_held_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= CNT_WAIT;
            header_reg     <= '0;
            second_reg     <= '0;
            left_held_reg  <= 1'b0;
            right_held_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (consume && sync)
            begin
                header_reg <= stage.data[LOW_W-1:0];
            end
            if (consume && !sync && count_reg == CNT_HEADER)
            begin
                second_reg <= stage.data;
            end
            if (consume && emit)
            begin
                left_held_reg  <= lbtn;
                right_held_reg <= rbtn;
            end
        end
    end

endmodule

// ===== rtl/core/smpd_out_stage.sv =====
module smpd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              emit,
    input  smpd_pkg::result_t result,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_stall,
    output smpd_pkg::result_t held
);
    import smpd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // the register may load when empty or when its request is taken
    assign advance = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= emit;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule

// ===== rtl/core/smpd_checker.sv =====
module smpd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic signed [smpd_pkg::DELTA_W-1:0] delta_x,
    input logic signed [smpd_pkg::DELTA_W-1:0] delta_y,
    input logic                             left_press,
    input logic                             left_release,
    input logic                             right_press,
    input logic                             right_release
);
    import smpd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result request dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(delta_x) && $stable(delta_y)
            && $stable(left_press) && $stable(left_release)
            && $stable(right_press) && $stable(right_release))
        else $error("result payload changed while stalled");

    // press and release of one button never come together
    a_button: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(left_press && left_release) && !(right_press && right_release))
        else $error("button press and release in one packet");

    // input backs up only behind a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // a fresh result follows an accepted byte that passed the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a matching input byte");

endmodule

bind serial_mouse_packet_decoder_top smpd_checker u_smpd_checker (.*);

// ===== test/tb_serial_mouse_packet_decoder_top.sv =====
module tb_serial_mouse_packet_decoder_top;

    import smpd_pkg::*;

    localparam int unsigned RANDOM_BYTES   = 600;
    localparam int unsigned HOLD_CYCLES    = 60;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned TIMEOUT_CYCLES = 200000;

    // expected packets, worked out from every accepted byte
    class mouse_scoreboard;
        logic [LOW_W-1:0]  header_bits;
        logic [BYTE_W-1:0] x_byte;
        count_t            position;
        logic              left_held;
        logic              right_held;
        result_t           pending[$];
        int unsigned       errors;
        int unsigned       packets;

        function new();
            header_bits = '0;
            x_byte      = '0;
            position    = CNT_WAIT;
            left_held   = 1'b0;
            right_held  = 1'b0;
            errors      = 0;
            packets     = 0;
        endfunction

        // advance the packet state by one accepted byte
        function void note_byte(logic [BYTE_W-1:0] b);
            result_t pkt;
            logic    lbtn;
            logic    rbtn;
            if (b[SYNC_IDX])
            begin
                header_bits = b[LOW_W-1:0];
                position    = CNT_HEADER;
            end
            else if (position == CNT_HEADER)
            begin
                x_byte   = b;
                position = CNT_SECOND;
            end
            else if (position != CNT_SECOND)
            begin
                // stray data byte, nothing to do
                position = CNT_WAIT;
            end
            else
            begin
                lbtn              = header_bits[LEFT_IDX];
                rbtn              = header_bits[RIGHT_IDX];
                pkt.delta_x       = {header_bits[1:0], x_byte[LOW_W-1:0]};
                pkt.delta_y       = {header_bits[3:2], b[LOW_W-1:0]};
                pkt.left_press    = lbtn;
                pkt.left_release  = !lbtn && left_held;
                pkt.right_press   = rbtn;
                pkt.right_release = !rbtn && right_held;
                left_held         = lbtn;
                right_held        = rbtn;
                position          = CNT_WAIT;
                pending.push_back(pkt);
            end
        endfunction

        // compare one delivered packet with the oldest expectation
        function void check_packet(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $error("packet with no expectation: dx %0d dy %0d", got.delta_x, got.delta_y);
                errors++;
                return;
            end
            want = pending.pop_front();
            packets++;
            if (got.delta_x !== want.delta_x)
            begin
                $error("delta_x: expected %0d, got %0d", want.delta_x, got.delta_x);
                errors++;
            end
            if (got.delta_y !== want.delta_y)
            begin
                $error("delta_y: expected %0d, got %0d", want.delta_y, got.delta_y);
                errors++;
            end
            if (got.left_press !== want.left_press)
            begin
                $error("left_press: expected %0b, got %0b", want.left_press, got.left_press);
                errors++;
            end
            if (got.left_release !== want.left_release)
            begin
                $error("left_release: expected %0b, got %0b",
                       want.left_release, got.left_release);
                errors++;
            end
            if (got.right_press !== want.right_press)
            begin
                $error("right_press: expected %0b, got %0b", want.right_press, got.right_press);
                errors++;
            end
            if (got.right_release !== want.right_release)
            begin
                $error("right_release: expected %0b, got %0b",
                       want.right_release, got.right_release);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [BYTE_W-1:0]         rx_byte;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic                      left_press;
    logic                      left_release;
    logic                      right_press;
    logic                      right_release;

    mouse_scoreboard sb = new();

    int unsigned bytes_sent;
    int unsigned stray_bytes;
    int unsigned burst_left;
    int unsigned blocked_cycles;
    int unsigned hold_asked;
    int unsigned hold_given;

    // directed bytes: stray at reset, extremes of delta_x, every button
    // press and release, stray after a packet, a packet cut short by a sync,
    // and two syncs in a row
    logic [BYTE_W-1:0] directed_bytes [26] = '{
        7'h15,
        7'h40, 7'h00, 7'h00,
        7'h7F, 7'h3F, 7'h3F,
        7'h40, 7'h3F, 7'h00,
        7'h62, 7'h00, 7'h3F,
        7'h2A,
        7'h5D, 7'h3F, 7'h00,
        7'h70, 7'h11, 7'h48, 7'h01, 7'h02,
        7'h60, 7'h4C, 7'h3F, 7'h3F
    };

    serial_mouse_packet_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .left_press    (left_press),
        .left_release  (left_release),
        .right_press   (right_press),
        .right_release (right_release)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // one byte request, preceded by a random gap at the start of each burst
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap_len;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            repeat (gap_len)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(b);
        bytes_sent++;
        burst_left--;
    endtask

    function automatic logic [BYTE_W-1:0] sync_byte();
        logic [BYTE_W-1:0] b;
        b           = BYTE_W'($urandom_range(0, 63));
        b[SYNC_IDX] = 1'b1;
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] data_byte();
        logic [BYTE_W-1:0] b;
        b           = BYTE_W'($urandom_range(0, 63));
        b[SYNC_IDX] = 1'b0;
        return b;
    endfunction

    // receiver: stall pattern changes every span, with long hold-offs on demand
    initial
    begin
        int unsigned mode;
        int unsigned span;
        int unsigned held;
        int unsigned tick;
        out_stall = 1'b0;
        held      = 0;
        tick      = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 60);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                if (hold_given < hold_asked)
                begin
                    out_stall <= 1'b1;
                    held++;
                    if (held == HOLD_CYCLES)
                    begin
                        held = 0;
                        hold_given++;
                    end
                end
                else
                begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= (tick % 3 == 0);
                    endcase
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_packet(result_t'{delta_x, delta_y, left_press, left_release,
                                      right_press, right_release});
        if (rst_n && in_valid && in_stall)
            blocked_cycles++;
    end

    // stimulus
    initial
    begin
        int unsigned kind;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        rx_byte        = '0;
        bytes_sent     = 0;
        stray_bytes    = 0;
        burst_left     = 0;
        blocked_cycles = 0;
        hold_asked     = 0;
        hold_given     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        // mostly well-formed packets, some stray bytes and cut packets
        while (bytes_sent < RANDOM_BYTES + $size(directed_bytes))
        begin
            if (bytes_sent > 250 && hold_asked == 0)
                hold_asked = 1;
            if (bytes_sent > 450 && hold_asked == 1)
                hold_asked = 2;
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                send_byte(sync_byte());
                send_byte(data_byte());
                send_byte(data_byte());
            end
            else if (kind == 7)
            begin
                send_byte(data_byte());
                stray_bytes++;
            end
            else if (kind == 8)
            begin
                send_byte(sync_byte());
                if ($urandom_range(0, 1) == 1)
                    send_byte(data_byte());
                stray_bytes++;
            end
            else
            begin
                send_byte(BYTE_W'($urandom_range(0, 127)));
                stray_bytes++;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // drain and let the pipeline settle
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d bytes, %0d of them stray or in cut packets; %0d packets checked",
                 bytes_sent, stray_bytes, sb.packets);
        $display("input held back for %0d cycles, %0d long output hold-offs",
                 blocked_cycles, hold_given);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * 12);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
